>>> rtl/core/huffman_code_bit_packer_defines.svh
// Assertion macros for the Huffman code bit packer.
// Included by the top level; depends on nothing else.
`ifndef HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HCBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hcbp check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HCBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcbp check failed");

`endif

>>> rtl/core/hcbp_pkg.sv
// Package for the Huffman code bit packer: item kinds, widths, result type.
// No dependencies.
`default_nettype none

package hcbp_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = 31;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             byte_present;
        logic [CNT_W-1:0] compressed_bytes;
        logic [CNT_W-1:0] coded_symbols;
        logic             last;
    } result_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/hcbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             re,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/hcbp_fifo.sv
// Small register queue with full and empty flags.
// No dependencies; DEPTH must be a power of two.
`default_nettype none

module hcbp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PTR_W = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  full,
    output logic                  empty
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == (PTR_W+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/hcbp_front.sv
// Front end: accepts items, keeps the code table, and issues coded-symbol
// and flush commands. Depends on hcbp_pkg and hcbp_ram.
`default_nettype none

module hcbp_front #(
    parameter int MAX_CODE_LEN  = 32,
    parameter int ALPHABET_SIZE = 256,
    localparam int LEN_W = $clog2(MAX_CODE_LEN + 1),
    localparam int AW    = $clog2(ALPHABET_SIZE)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [1:0]                    kind,
    input  wire logic [7:0]                    symbol,
    input  wire logic [hcbp_pkg::WORD_W-1:0]   code_bits,
    input  wire logic [5:0]                    code_length,
    input  wire logic                          code_present,
    output logic                               cmd_push,
    input  wire logic                          cmd_full,
    output logic                               cmd_flush,
    output logic [hcbp_pkg::WORD_W-1:0]        cmd_word,
    output logic [LEN_W-1:0]                   cmd_len
);

    import hcbp_pkg::*;

    localparam int ENT_W = WORD_W + LEN_W;

    logic [ALPHABET_SIZE-1:0] present_reg;
    logic                     valid_reg;
    logic                     flush_reg;
    logic                     hit_reg;
    logic                     accept;
    logic                     advance;
    logic                     in_range;
    logic [AW-1:0]            index;
    logic [LEN_W-1:0]         len_sat;
    logic [WORD_W-1:0]        len_mask;
    logic                     tbl_we;
    logic                     tbl_re;
    logic [ENT_W-1:0]         tbl_rd_data;

    assign full     = valid_reg && cmd_full;
    assign accept   = push && !full;
    assign advance  = !valid_reg || !cmd_full;
    assign in_range = ({1'b0, symbol} < 9'(ALPHABET_SIZE));
    assign index    = symbol[AW-1:0];
    assign tbl_we   = accept && (kind == KIND_LOAD) && in_range;
    assign tbl_re   = accept && (kind == KIND_DATA);

    always_comb
    begin
        if (code_length > 6'(MAX_CODE_LEN))
        begin
            len_sat = LEN_W'(MAX_CODE_LEN);
        end
        else
        begin
            len_sat = LEN_W'(code_length);
        end
        for (int i = 0; i < WORD_W; i++)
        begin
            len_mask[i] = (i < int'(len_sat));
        end
    end

    hcbp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_table (
        .clk     (clk),
        .we      (tbl_we),
        .wr_addr (index),
        .wr_data ({code_bits & len_mask, len_sat}),
        .re      (tbl_re),
        .rd_addr (index),
        .rd_data (tbl_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            valid_reg   <= 1'b0;
            flush_reg   <= 1'b0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            if (tbl_we)
            begin
                present_reg[index] <= code_present;
            end
            if (accept)
            begin
                valid_reg <= (kind == KIND_DATA) || (kind == KIND_FLUSH);
                flush_reg <= (kind == KIND_FLUSH);
                hit_reg   <= in_range && present_reg[index];
            end
            else if (advance)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign cmd_push  = valid_reg && (flush_reg || hit_reg) && !cmd_full;
    assign cmd_flush = flush_reg;
    assign cmd_word  = tbl_rd_data[ENT_W-1:LEN_W];
    assign cmd_len   = tbl_rd_data[LEN_W-1:0];

endmodule

`default_nettype wire

>>> rtl/core/hcbp_back.sv
// Back end: packs code words into bytes, keeps the totals, and builds results.
// Depends on hcbp_pkg.
`default_nettype none

module hcbp_back #(
    parameter int MAX_CODE_LEN = 32,
    localparam int LEN_W = $clog2(MAX_CODE_LEN + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmd_empty,
    output logic                             cmd_pop,
    input  wire logic                        cmd_flush,
    input  wire logic [hcbp_pkg::WORD_W-1:0] cmd_word,
    input  wire logic [LEN_W-1:0]            cmd_len,
    input  wire logic                        out_full,
    output logic                             out_push,
    output hcbp_pkg::result_t                out_result
);

    import hcbp_pkg::*;

    logic              busy_reg;
    logic [LEN_W-1:0]  rem_reg;
    logic [WORD_W-1:0] word_reg;
    logic [6:0]        acc_reg;
    logic [2:0]        cnt_reg;
    logic [CNT_W-1:0]  bytes_reg;
    logic [CNT_W-1:0]  syms_reg;

    logic              start;
    logic              do_flush;
    logic              step;
    logic [6:0]        cur_rem;
    logic [WORD_W-1:0] cur_word;
    logic [3:0]        take;
    logic [6:0]        rem_left;
    logic [7:0]        take_mask;
    logic [7:0]        new_bits;
    logic [14:0]       merged;
    logic [3:0]        total;
    logic              emit;
    logic [2:0]        keep;
    logic [6:0]        acc_new;
    logic              last_byte;
    logic [CNT_W-1:0]  syms_use;
    logic [7:0]        pad_byte;

    assign start    = !busy_reg && !cmd_empty && !out_full;
    assign do_flush = start && cmd_flush;
    assign step     = (busy_reg && !out_full) || (start && !cmd_flush);
    assign cmd_pop  = start;

    always_comb
    begin
        cur_rem   = busy_reg ? 7'(rem_reg) : 7'(cmd_len);
        cur_word  = busy_reg ? word_reg : cmd_word;
        take      = (cur_rem >= 7'd8) ? 4'd8 : 4'(cur_rem);
        rem_left  = cur_rem - 7'(take);
        take_mask = 8'((9'd1 << take) - 9'd1);
        new_bits  = 8'(cur_word >> rem_left) & take_mask;
        merged    = (15'(acc_reg) << take) | 15'(new_bits);
        total     = 4'(cnt_reg) + take;
        emit      = total[3];
        keep      = emit ? 3'(total - 4'd8) : 3'(total);
        acc_new   = 7'(merged) & 7'((8'd1 << keep) - 8'd1);
        last_byte = ((7'(keep) + rem_left) < 7'd8);
        syms_use  = start ? sat_inc(syms_reg) : syms_reg;
        pad_byte  = 8'({1'b0, acc_reg} << (4'd8 - 4'(cnt_reg)));
    end

    always_comb
    begin
        out_push = do_flush || (step && emit);
        if (do_flush)
        begin
            out_result.out_byte         = pad_byte;
            out_result.byte_present     = (cnt_reg != 3'd0);
            out_result.compressed_bytes = (cnt_reg != 3'd0) ? sat_inc(bytes_reg) : bytes_reg;
            out_result.coded_symbols    = syms_reg;
            out_result.last             = 1'b1;
        end
        else
        begin
            out_result.out_byte         = 8'(merged >> (total - 4'd8));
            out_result.byte_present     = 1'b1;
            out_result.compressed_bytes = sat_inc(bytes_reg);
            out_result.coded_symbols    = syms_use;
            out_result.last             = last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            rem_reg   <= '0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            bytes_reg <= '0;
            syms_reg  <= '0;
        end
        else if (do_flush)
        begin
            acc_reg   <= '0;
            cnt_reg   <= '0;
            bytes_reg <= '0;
            syms_reg  <= '0;
        end
        else if (step)
        begin
            busy_reg <= (rem_left != 7'd0);
            rem_reg  <= LEN_W'(rem_left);
            acc_reg  <= acc_new;
            cnt_reg  <= keep;
            syms_reg <= syms_use;
            if (emit)
            begin
                bytes_reg <= sat_inc(bytes_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            word_reg <= cur_word;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/huffman_code_bit_packer.sv
// Top level of the Huffman code bit packer: front end, command queue,
// back end and result queue. Depends on hcbp_pkg, the hcbp_* modules
// and huffman_code_bit_packer_defines.svh.
`default_nettype none

// The block takes one item in every cycle while full is low. Table loads
// take effect for the very next item, and the table needs no clearing after
// reset because each entry has its own present flag. A four-entry command
// queue sits between the table lookup and the bit packer, and a four-entry
// result queue sits behind the packer. The packer handles a flush at once
// and takes up to eight bits of a code word at a time, emitting at most
// one byte per cycle, so codes of up to eight bits sustain one item per cycle;
// longer codes and a stalled pop fill the queues and then raise full.
module huffman_code_bit_packer #(
    parameter int MAX_CODE_LEN  = 32,
    parameter int ALPHABET_SIZE = 256,
    localparam int LEN_W = $clog2(MAX_CODE_LEN + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [1:0]                  kind,
    input  wire logic [7:0]                  symbol,
    input  wire logic [hcbp_pkg::WORD_W-1:0] code_bits,
    input  wire logic [5:0]                  code_length,
    input  wire logic                        code_present,
    output logic                             empty,
    input  wire logic                        pop,
    output logic [7:0]                       out_byte,
    output logic                             byte_present,
    output logic [hcbp_pkg::CNT_W-1:0]       compressed_bytes,
    output logic [hcbp_pkg::CNT_W-1:0]       coded_symbols,
    output logic                             last
);

    import hcbp_pkg::*;

    `include "huffman_code_bit_packer_defines.svh"

    localparam int CMD_W = 1 + WORD_W + LEN_W;

    logic              cmd_push;
    logic              cmd_full;
    logic              cmd_empty;
    logic              cmd_pop;
    logic              f_flush;
    logic [WORD_W-1:0] f_word;
    logic [LEN_W-1:0]  f_len;
    logic [CMD_W-1:0]  cmd_head;
    logic              out_push;
    logic              out_full;
    logic              flush_start;
    result_t           back_result;
    result_t           head_result;

    hcbp_front #(
        .MAX_CODE_LEN  (MAX_CODE_LEN),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .kind         (kind),
        .symbol       (symbol),
        .code_bits    (code_bits),
        .code_length  (code_length),
        .code_present (code_present),
        .cmd_push     (cmd_push),
        .cmd_full     (cmd_full),
        .cmd_flush    (f_flush),
        .cmd_word     (f_word),
        .cmd_len      (f_len)
    );

    hcbp_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (4)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data ({f_flush, f_word, f_len}),
        .rd_en   (cmd_pop),
        .rd_data (cmd_head),
        .full    (cmd_full),
        .empty   (cmd_empty)
    );

    hcbp_back #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_empty  (cmd_empty),
        .cmd_pop    (cmd_pop),
        .cmd_flush  (cmd_head[CMD_W-1]),
        .cmd_word   (cmd_head[CMD_W-2:LEN_W]),
        .cmd_len    (cmd_head[LEN_W-1:0]),
        .out_full   (out_full),
        .out_push   (out_push),
        .out_result (back_result)
    );

    hcbp_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (4)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (back_result),
        .rd_en   (pop),
        .rd_data (head_result),
        .full    (out_full),
        .empty   (empty)
    );

    assign out_byte         = head_result.out_byte;
    assign byte_present     = head_result.byte_present;
    assign compressed_bytes = head_result.compressed_bytes;
    assign coded_symbols    = head_result.coded_symbols;
    assign last             = head_result.last;

    assign flush_start = cmd_pop && cmd_head[CMD_W-1];

    `HCBP_ASSERT_NOW(a_cmd_no_overflow, clk, rst_n, cmd_push, !cmd_full)
    `HCBP_ASSERT_NOW(a_out_no_overflow, clk, rst_n, out_push, !out_full)
    `HCBP_ASSERT_NOW(a_no_byte_is_last, clk, rst_n, !empty && !byte_present, last)
    `HCBP_ASSERT_NEXT(a_flush_clears, clk, rst_n, flush_start,
                      u_back.cnt_reg == 3'd0 && u_back.bytes_reg == '0)

endmodule

`default_nettype wire
